>>> hdl/lpmd_pkg.sv
// ----------------------------------------------------------------------------
// lpmd_pkg
// Shared types and constants for the length-prefixed message deframer.
// ----------------------------------------------------------------------------
package lpmd_pkg;

    // header geometry
    localparam int unsigned HDR_LEN = 12;
    localparam int unsigned HC_W    = 4;

    // result status codes
    localparam logic [1:0] ST_HEADER  = 2'd0;
    localparam logic [1:0] ST_PAYLOAD = 2'd1;
    localparam logic [1:0] ST_REJECT  = 2'd2;

    // one result beat
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] msg_type;
        logic [15:0] msg_cmd;
        logic [15:0] msg_index;
        logic [15:0] msg_total;
        logic [31:0] msg_length;
        logic [7:0]  payload_byte;
        logic        last;
    } t_result;

endpackage

>>> hdl/lpmd_parse.sv
// ----------------------------------------------------------------------------
// lpmd_parse
// Header collection and payload counting; forms at most one result per input beat.
// ----------------------------------------------------------------------------
module lpmd_parse (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [31:0]          i_max_len,
    input  logic                 i_beat,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_resync,
    output logic                 o_res_valid,
    output lpmd_pkg::t_result    o_res
);

    localparam logic [lpmd_pkg::HC_W-1:0] HC_LAST = lpmd_pkg::HC_W'(lpmd_pkg::HDR_LEN - 1);
    localparam logic [lpmd_pkg::HC_W-1:0] HC_END  = lpmd_pkg::HC_W'(lpmd_pkg::HDR_LEN);

    logic                        r_in_payload, n_in_payload;
    logic [lpmd_pkg::HC_W-1:0]   r_hdr_cnt, n_hdr_cnt;
    logic [31:0]                 r_remain, n_remain;
    logic [7:0]                  r_hdr [lpmd_pkg::HDR_LEN];

    logic [lpmd_pkg::HC_W-1:0]   wr_idx;
    logic [31:0]                 new_len;
    logic [31:0]                 stored_len;

    // write slot, restarting on an out-of-range count
    assign wr_idx = (r_hdr_cnt >= HC_END) ? '0 : r_hdr_cnt;

    // length of a header completing with this beat, last byte from the input
    assign new_len    = {r_hdr[8], r_hdr[9], r_hdr[10], i_data_byte};
    assign stored_len = {r_hdr[8], r_hdr[9], r_hdr[10], r_hdr[11]};

    // next state and result
    always_comb begin
        n_in_payload = r_in_payload;
        n_hdr_cnt    = r_hdr_cnt;
        n_remain     = r_remain;
        o_res_valid  = 1'b0;
        o_res        = '0;
        if (i_beat) begin
            if (i_resync) begin
                n_in_payload = 1'b0;
                n_hdr_cnt    = '0;
                n_remain     = '0;
            end else if (!r_in_payload) begin
                n_hdr_cnt = wr_idx + 1'b1;
                if (wr_idx == HC_LAST) begin
                    o_res_valid      = 1'b1;
                    o_res.msg_type   = {r_hdr[0], r_hdr[1]};
                    o_res.msg_cmd    = {r_hdr[2], r_hdr[3]};
                    o_res.msg_index  = {r_hdr[4], r_hdr[5]};
                    o_res.msg_total  = {r_hdr[6], r_hdr[7]};
                    o_res.msg_length = new_len;
                    n_hdr_cnt        = '0;
                    if (new_len > i_max_len) begin
                        o_res.status = lpmd_pkg::ST_REJECT;
                        n_remain     = '0;
                    end else if (new_len == '0) begin
                        o_res.status = lpmd_pkg::ST_HEADER;
                        o_res.last   = 1'b1;
                        n_remain     = '0;
                    end else begin
                        o_res.status = lpmd_pkg::ST_HEADER;
                        n_in_payload = 1'b1;
                        n_remain     = new_len;
                    end
                end
            end else begin
                o_res_valid        = 1'b1;
                o_res.status       = lpmd_pkg::ST_PAYLOAD;
                o_res.msg_length   = stored_len;
                o_res.payload_byte = i_data_byte;
                if (r_remain <= 32'd1) begin
                    o_res.last   = 1'b1;
                    n_in_payload = 1'b0;
                    n_hdr_cnt    = '0;
                    n_remain     = '0;
                end else begin
                    n_remain = r_remain - 32'd1;
                end
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_payload <= 1'b0;
            r_hdr_cnt    <= '0;
            r_remain     <= '0;
        end else begin
            r_in_payload <= n_in_payload;
            r_hdr_cnt    <= n_hdr_cnt;
            r_remain     <= n_remain;
        end
    end

    // header byte store, written while hunting
    always_ff @(posedge i_clk) begin
        if (i_beat && !i_resync && !r_in_payload) begin
            r_hdr[wr_idx] <= i_data_byte;
        end
    end

endmodule

>>> hdl/lpmd_outreg.sv
// ----------------------------------------------------------------------------
// lpmd_outreg
// Result register with a skid stage; ready toward the parser is registered.
// ----------------------------------------------------------------------------
module lpmd_outreg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_res_valid,
    input  lpmd_pkg::t_result  i_res,
    output logic               o_space,
    output logic               o_valid,
    input  logic               i_ready,
    output lpmd_pkg::t_result  o_res
);

    logic               r_out_valid;
    logic               r_skid_valid;
    lpmd_pkg::t_result  r_out;
    lpmd_pkg::t_result  r_skid;
    logic               out_free;

    assign out_free = !r_out_valid || i_ready;
    assign o_space  = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_res    = r_out;

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || i_res_valid;
            r_skid_valid <= 1'b0;
        end else if (i_res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : i_res;
        end else if (i_res_valid) begin
            r_skid <= i_res;
        end
    end

endmodule

>>> hdl/length_prefixed_message_deframer.sv
// ----------------------------------------------------------------------------
// length_prefixed_message_deframer
// Splits a byte stream into 12-byte big-endian headers and counted payloads.
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_ready) carries one stream byte per beat plus a
// resync flag that drops the byte and restarts header hunting. The output
// channel (o_valid/i_ready) carries one result per header or payload byte:
// status 0 header accepted, 1 payload byte, 2 header rejected because its
// length exceeds max_payload_length; last marks the final payload byte or
// the header of an empty message. Header bytes and resync beats give no
// result. i_cfg_we writes max_payload_length (reset value 65535); the user
// must use it only while the block is idle, which the block does not enforce.
// Each result is held in the output register (or the skid stage) until taken.
// Throughput: one byte per cycle while o_ready is high; the parser's next
// state and result come from one pass of counter update and 32-bit compare.
// While the receiver stalls, results collect in the output register and a
// one-entry skid stage; o_ready drops only once both are full.
// Reset (synchronous, active low) returns the parser to header hunting and
// empties the output stages.
// ----------------------------------------------------------------------------
module length_prefixed_message_deframer #(
    parameter logic [31:0] MAX_LEN_RESET = 32'd65535
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_resync,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_msg_type,
    output logic [15:0] o_msg_cmd,
    output logic [15:0] o_msg_index,
    output logic [15:0] o_msg_total,
    output logic [31:0] o_msg_length,
    output logic [7:0]  o_payload_byte,
    output logic        o_last
);

    logic [31:0]        r_max_len;
    logic               beat;
    logic               res_valid;
    lpmd_pkg::t_result  res;
    lpmd_pkg::t_result  out_res;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_wdata;
        end
    end

    assign beat = i_valid && o_ready;

    lpmd_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_max_len   (r_max_len),
        .i_beat      (beat),
        .i_data_byte (i_data_byte),
        .i_resync    (i_resync),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    lpmd_outreg u_outreg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_space     (o_ready),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_res       (out_res)
    );

    assign o_status       = out_res.status;
    assign o_msg_type     = out_res.msg_type;
    assign o_msg_cmd      = out_res.msg_cmd;
    assign o_msg_index    = out_res.msg_index;
    assign o_msg_total    = out_res.msg_total;
    assign o_msg_length   = out_res.msg_length;
    assign o_payload_byte = out_res.payload_byte;
    assign o_last         = out_res.last;

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for length_prefixed_message_deframer. A queue of stream
// beats feeds a bursty driver. Each accepted beat runs through a behavioral
// deframer that queues the result it should produce. A monitor checks every
// output beat, field by field, against that queue under random receiver stalls.
// ----------------------------------------------------------------------------
module testbench;

    // one input beat: stream byte plus resync flag
    typedef struct packed {
        logic [7:0] data;
        logic       resync;
    } t_beat;

    // DUT ports
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [31:0] i_cfg_wdata = '0;
    logic        i_valid     = 1'b0;
    logic [7:0]  i_data_byte = '0;
    logic        i_resync    = 1'b0;
    logic        i_ready     = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [15:0] o_msg_type;
    logic [15:0] o_msg_cmd;
    logic [15:0] o_msg_index;
    logic [15:0] o_msg_total;
    logic [31:0] o_msg_length;
    logic [7:0]  o_payload_byte;
    logic        o_last;

    // stimulus and expected results
    t_beat             stream_q[$];
    lpmd_pkg::t_result results_due[$];

    // deframer shadow state
    logic        in_body     = 1'b0;
    logic [3:0]  hdr_cnt     = '0;
    logic [7:0]  hdr_buf [lpmd_pkg::HDR_LEN];
    logic [31:0] body_left   = '0;
    logic [31:0] max_len     = 32'd65535;

    // bookkeeping
    int n_pushed   = 0;
    int n_accepted = 0;
    int n_errors   = 0;
    int n_headers  = 0;
    int n_body     = 0;
    int n_rejects  = 0;
    int n_resyncs  = 0;
    int n_settings = 0;

    // sender / receiver pacing
    int          burst_left = 8;
    int          gap_left   = 0;
    int          rdy_tick   = 0;
    int          rdy_mode   = 0;
    logic [15:0] rdy_mask   = '1;
    logic [7:0]  rdy_pos    = '0;

    length_prefixed_message_deframer u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .i_resync       (i_resync),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_msg_type     (o_msg_type),
        .o_msg_cmd      (o_msg_cmd),
        .o_msg_index    (o_msg_index),
        .o_msg_total    (o_msg_total),
        .o_msg_length   (o_msg_length),
        .o_payload_byte (o_payload_byte),
        .o_last         (o_last)
    );

    // clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [31:0] hdr_length();
        return {hdr_buf[8], hdr_buf[9], hdr_buf[10], hdr_buf[11]};
    endfunction

    // advance the shadow deframer by one accepted beat
    task automatic deframe_beat(input logic [7:0] b, input logic rs);
        lpmd_pkg::t_result r;
        r = '0;
        if (rs) begin
            in_body   = 1'b0;
            hdr_cnt   = '0;
            body_left = '0;
            n_resyncs++;
            return;
        end
        if (!in_body) begin
            if (hdr_cnt >= lpmd_pkg::HDR_LEN)
                hdr_cnt = '0;
            hdr_buf[hdr_cnt] = b;
            hdr_cnt = hdr_cnt + 4'd1;
            if (hdr_cnt < lpmd_pkg::HDR_LEN)
                return;
            r.msg_type   = {hdr_buf[0], hdr_buf[1]};
            r.msg_cmd    = {hdr_buf[2], hdr_buf[3]};
            r.msg_index  = {hdr_buf[4], hdr_buf[5]};
            r.msg_total  = {hdr_buf[6], hdr_buf[7]};
            r.msg_length = hdr_length();
            hdr_cnt = '0;
            if (r.msg_length > max_len) begin
                r.status  = lpmd_pkg::ST_REJECT;
                body_left = '0;
                n_rejects++;
            end else if (r.msg_length == 0) begin
                r.status = lpmd_pkg::ST_HEADER;
                r.last   = 1'b1;
                n_headers++;
            end else begin
                r.status  = lpmd_pkg::ST_HEADER;
                in_body   = 1'b1;
                body_left = r.msg_length;
                n_headers++;
            end
        end else begin
            r.status       = lpmd_pkg::ST_PAYLOAD;
            r.msg_length   = hdr_length();
            r.payload_byte = b;
            n_body++;
            if (body_left <= 1) begin
                r.last    = 1'b1;
                in_body   = 1'b0;
                hdr_cnt   = '0;
                body_left = '0;
            end else begin
                body_left = body_left - 1;
            end
        end
        results_due.push_back(r);
    endtask

    task automatic report_error(input string what, input logic [31:0] got,
                                input logic [31:0] want);
        if (n_errors < 40)
            $display("ERROR at %0t: %s got %h expected %h", $time, what, got, want);
        n_errors++;
    endtask

    // driver: bursts of beats with random gaps
    always @(posedge i_clk) begin : drv
        t_beat nb;
        logic  nv;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            nv = i_valid;
            if (i_valid && o_ready) begin
                deframe_beat(i_data_byte, i_resync);
                n_accepted++;
                nv = 1'b0;
            end
            if (!nv) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (stream_q.size() > 0) begin
                    nb = stream_q.pop_front();
                    i_data_byte <= nb.data;
                    i_resync    <= nb.resync;
                    nv = 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
            i_valid <= nv;
        end
    end

    // receiver: stall pattern, redrawn each time its tick count runs out
    always @(posedge i_clk) begin : rcv
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (rdy_tick == 0) begin
                rdy_mode = $urandom_range(0, 3);
                rdy_mask = 16'($urandom());
                rdy_tick = $urandom_range(16, 96);
            end else begin
                rdy_tick--;
            end
            rdy_pos = rdy_pos + 8'd1;
            case (rdy_mode)
                0: i_ready <= 1'b1;
                1: i_ready <= rdy_mask[rdy_pos[3:0]];
                2: i_ready <= ($urandom_range(0, 3) == 0);
                default: i_ready <= (rdy_pos[2:0] == 3'd0);
            endcase
        end
    end

    // monitor: compare each output beat with the oldest expectation
    always @(posedge i_clk) begin : mon
        lpmd_pkg::t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (results_due.size() == 0) begin
                report_error("result with none expected, status", 32'(o_status), '0);
            end else begin
                want = results_due.pop_front();
                if (o_status !== want.status)
                    report_error("status", 32'(o_status), 32'(want.status));
                if (o_msg_type !== want.msg_type)
                    report_error("msg_type", 32'(o_msg_type), 32'(want.msg_type));
                if (o_msg_cmd !== want.msg_cmd)
                    report_error("msg_cmd", 32'(o_msg_cmd), 32'(want.msg_cmd));
                if (o_msg_index !== want.msg_index)
                    report_error("msg_index", 32'(o_msg_index), 32'(want.msg_index));
                if (o_msg_total !== want.msg_total)
                    report_error("msg_total", 32'(o_msg_total), 32'(want.msg_total));
                if (o_msg_length !== want.msg_length)
                    report_error("msg_length", o_msg_length, want.msg_length);
                if (o_payload_byte !== want.payload_byte)
                    report_error("payload_byte", 32'(o_payload_byte),
                                 32'(want.payload_byte));
                if (o_last !== want.last)
                    report_error("last", 32'(o_last), 32'(want.last));
            end
        end
    end

    // ---- stimulus helpers ----
    task automatic add_beat(input logic [7:0] b, input logic rs);
        stream_q.push_back('{data: b, resync: rs});
        n_pushed++;
    endtask

    task automatic add_header(input logic [15:0] t, input logic [15:0] c,
                              input logic [15:0] x, input logic [15:0] tot,
                              input logic [31:0] len);
        add_beat(t[15:8], 1'b0);   add_beat(t[7:0], 1'b0);
        add_beat(c[15:8], 1'b0);   add_beat(c[7:0], 1'b0);
        add_beat(x[15:8], 1'b0);   add_beat(x[7:0], 1'b0);
        add_beat(tot[15:8], 1'b0); add_beat(tot[7:0], 1'b0);
        add_beat(len[31:24], 1'b0); add_beat(len[23:16], 1'b0);
        add_beat(len[15:8], 1'b0);  add_beat(len[7:0], 1'b0);
    endtask

    task automatic add_rand_header(input logic [31:0] len);
        add_header(16'($urandom()), 16'($urandom()), 16'($urandom()),
                   16'($urandom()), len);
    endtask

    // body bytes, cut short by a resync beat after n of them
    task automatic add_cut_body(input int n);
        for (int i = 0; i < n; i++)
            add_beat(8'($urandom()), 1'b0);
        add_beat(8'($urandom()), 1'b1);
    endtask

    function automatic logic [31:0] pick_len(input logic [31:0] limit);
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return (limit <= 64) ? limit : 32'($urandom_range(17, 64));
            2: return (limit != '1) ? limit + 1 : 32'($urandom());
            default: return 32'($urandom_range(1, 16));
        endcase
    endfunction

    // one random sequence: mostly whole messages, some broken ones and noise
    task automatic add_sequence(input logic [31:0] limit);
        int          kind;
        int          n;
        logic [31:0] len;
        kind = $urandom_range(0, 19);
        if (kind < 13) begin
            len = pick_len(limit);
            add_rand_header(len);
            if (len != 0 && len <= limit) begin
                if (len <= 64) begin
                    for (int i = 0; i < len; i++)
                        add_beat(8'($urandom()), 1'b0);
                end else begin
                    add_cut_body($urandom_range(1, 12));
                end
            end
        end else if (kind < 15) begin
            // any 32-bit length
            len = $urandom();
            add_rand_header(len);
            if (len != 0 && len <= limit)
                add_cut_body($urandom_range(1, 12));
        end else if (kind < 17) begin
            // header cut short
            n = $urandom_range(1, 11);
            add_cut_body(n);
        end else if (kind < 19) begin
            // body cut short
            len = $urandom_range(2, 20);
            add_rand_header(len);
            if (len <= limit)
                add_cut_body($urandom_range(1, len - 1));
        end else begin
            // noise with stray resyncs, then realign
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
                add_beat(8'($urandom()), ($urandom_range(0, 7) == 0));
            add_beat(8'($urandom()), 1'b1);
        end
    endtask

    task automatic run_phase(input logic [31:0] limit, input int target);
        int start;
        start = n_pushed;
        while (n_pushed - start < target)
            add_sequence(limit);
    endtask

    // wait until every beat is taken and every result has come out
    task automatic wait_idle();
        @(negedge i_clk);
        while (!(n_accepted == n_pushed && results_due.size() == 0 && !i_valid))
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_max_len(input logic [31:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        max_len = v;
        n_settings++;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // main sequence
    initial begin : stim
        logic [31:0] limits [6];
        limits[0] = 32'd0;
        limits[1] = 32'hFFFF_FFFF;
        limits[2] = 32'd1;
        limits[3] = $urandom_range(2, 40);
        limits[4] = 32'h8000_0000;
        limits[5] = 32'd65535;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty message with all-ones fields
        add_header(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd0);
        // largest length, rejected at the reset limit
        add_header(16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
        // resync while hunting, then a header cut by resync
        add_beat(8'hFF, 1'b1);
        add_beat(8'h00, 1'b0);
        add_beat(8'hFF, 1'b0);
        add_beat(8'h5A, 1'b1);

        run_phase(32'd65535, 218);
        wait_idle();
        foreach (limits[k]) begin
            write_max_len(limits[k]);
            run_phase(limits[k], 218);
            wait_idle();
        end
        repeat (8) @(posedge i_clk);

        $display("Covered %0d beats over %0d limit settings: %0d headers, %0d rejects,",
                 n_accepted, n_settings + 1, n_headers, n_rejects);
        $display("  %0d payload bytes and %0d resyncs under bursty input and stalls.",
                 n_body, n_resyncs);
        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> filelist.f
hdl/lpmd_pkg.sv
hdl/lpmd_parse.sv
hdl/lpmd_outreg.sv
hdl/length_prefixed_message_deframer.sv
tb/testbench.sv
